// File: sv/owt_pkg.sv
package owt_pkg;

    localparam int MAX_WINDOWS_DEF = 8;

    localparam int ADDR_W       = 48;
    localparam int BUS_ADDR_W   = 64;
    localparam int SIZE_LOG2_W  = 5;
    localparam int COUNT_W      = 4;
    localparam int STATUS_W     = 2;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 48;
    localparam int S_DATA_W     = ADDR_W + BUS_ADDR_W;
    localparam int M_DATA_W     = 8;

    // request kinds
    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_LOG2 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT     = 2'd2;

    localparam logic [ADDR_W-1:0]      BASE_RST      = '0;
    localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_RST = 5'd12;
    localparam logic [COUNT_W-1:0]     COUNT_RST     = 4'd1;

    typedef struct packed {
        logic [31:0]       upper;
        logic [31:0]       lower;
        logic [ADDR_W-1:0] laddr;
    } owt_entry_t;

endpackage

// File: sv/owt_entry_ram.sv
module owt_entry_ram #(
    parameter int MAX_WINDOWS = owt_pkg::MAX_WINDOWS_DEF,
    parameter int IDX_W       = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [IDX_W-1:0]    waddr,
    input  owt_pkg::owt_entry_t wdata,
    input  logic [IDX_W-1:0]    raddr,
    output owt_pkg::owt_entry_t rdata
);
    import owt_pkg::*;

    owt_entry_t mem [MAX_WINDOWS];
    owt_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/outbound_window_translation_table.sv
// outbound window translation table
// input words on s_*: s_tuser is the request kind (map or unmap), s_tdata carries
// the local address and the bus address. every request returns exactly one word
// on m_* holding a 2-bit status (done, out of range, not found).
// the window set-up (base, log2 size, count) must be written through cfg_wr_*
// only while no request is in flight; the block itself does not enforce this.
// a map goes from accept to result by subtracting the base, then the shift and
// range check plus the entry write, then loading the output register.
// an unmap walks the entry memory one entry per cycle through its single read
// port, whose read data is registered, and stops early when an entry hits.
// one request is worked on at a time; a new one is accepted while the previous
// status still waits in the output register.
// reset clears the valid bits (entries read as zero until mapped) and loads the
// set-up registers with base 0, size 4 KiB, one window. no clearing pass.
// when m_tready is low the status word holds and the block stops after finishing
// the request it has taken.
module outbound_window_translation_table #(
    parameter int MAX_WINDOWS = owt_pkg::MAX_WINDOWS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [owt_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  logic [owt_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [owt_pkg::S_DATA_W-1:0]       s_tdata,  // local_address, bus_address
    input  logic                               s_tuser,  // operation
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [owt_pkg::M_DATA_W-1:0]       m_tdata   // status, zero fill
);
    import owt_pkg::*;

    localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MAP_SUB = 3'd1;
    localparam logic [2:0] S_MAP_CHK = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [ADDR_W-1:0]      base_reg;
    logic [SIZE_LOG2_W-1:0] size_log2_reg;
    logic [COUNT_W-1:0]     count_reg;

    logic                   op_reg, op_next;
    logic [ADDR_W-1:0]      laddr_reg, laddr_next;
    logic [BUS_ADDR_W-1:0]  baddr_reg, baddr_next;
    logic [ADDR_W:0]        diff_reg, diff_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]       chk_idx_reg, chk_idx_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic                   rd_valid_reg;

    logic [MAX_WINDOWS-1:0] vld_reg, vld_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;

    logic [CNT_W-1:0]       n_used;
    logic [ADDR_W-1:0]      off_hi;
    logic [31:0]            low_mask;
    logic [ADDR_W-1:0]      stored_laddr;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    owt_entry_t             ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    owt_entry_t             ram_rdata;

    owt_entry_ram #(
        .MAX_WINDOWS (MAX_WINDOWS),
        .IDX_W       (IDX_W)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // windows in use, limited to the built maximum
    assign n_used = (32'(count_reg) > 32'(MAX_WINDOWS)) ? CNT_W'(MAX_WINDOWS)
                                                        : CNT_W'(count_reg);

    assign off_hi    = diff_reg[ADDR_W-1:0] >> size_log2_reg;
    assign low_mask  = 32'((33'd1 << size_log2_reg) - 33'd1);
    assign ram_raddr = rd_idx_reg[IDX_W-1:0];
    // an entry never mapped since its last clear reads as zero
    assign stored_laddr = rd_valid_reg ? ram_rdata.laddr : '0;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(m_status_reg);

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        laddr_next    = laddr_reg;
        baddr_next    = baddr_reg;
        diff_next     = diff_reg;
        status_next   = status_reg;
        rd_idx_next   = rd_idx_reg;
        chk_idx_next  = chk_idx_reg;
        chk_vld_next  = 1'b0;
        vld_next      = vld_reg;
        m_tvalid_next = m_tvalid_reg;
        m_status_next = m_status_reg;
        ram_we        = 1'b0;
        ram_waddr     = chk_idx_reg[IDX_W-1:0];
        ram_wdata     = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = s_tuser;
                    laddr_next  = s_tdata[ADDR_W-1:0];
                    baddr_next  = s_tdata[S_DATA_W-1:ADDR_W];
                    rd_idx_next = '0;
                    if (s_tuser == OP_MAP) begin
                        state_next = S_MAP_SUB;
                    end else if (n_used == '0) begin
                        status_next = STAT_MISS;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_MAP_SUB: begin
                // top bit is the borrow: address below the base
                diff_next  = {1'b0, laddr_reg} - {1'b0, base_reg};
                state_next = S_MAP_CHK;
            end
            S_MAP_CHK: begin
                if (!diff_reg[ADDR_W] && (off_hi < ADDR_W'(n_used))) begin
                    ram_we          = 1'b1;
                    ram_waddr       = off_hi[IDX_W-1:0];
                    ram_wdata.upper = baddr_reg[63:32];
                    ram_wdata.lower = baddr_reg[31:0] & ~low_mask;
                    ram_wdata.laddr = laddr_reg;
                    vld_next[off_hi[IDX_W-1:0]] = 1'b1;
                    status_next     = STAT_DONE;
                end else begin
                    status_next = STAT_RANGE;
                end
                state_next = S_DONE;
            end
            S_SCAN: begin
                // issue the next read while the previous entry is compared
                if (rd_idx_reg < n_used) begin
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    chk_idx_next = rd_idx_reg;
                    chk_vld_next = 1'b1;
                end
                if (chk_vld_reg) begin
                    if (stored_laddr == laddr_reg) begin
                        ram_we      = 1'b1;
                        vld_next[chk_idx_reg[IDX_W-1:0]] = 1'b0;
                        status_next  = STAT_DONE;
                        chk_vld_next = 1'b0;
                        state_next   = S_DONE;
                    end else if (chk_idx_reg + CNT_W'(1) == n_used) begin
                        status_next  = STAT_MISS;
                        chk_vld_next = 1'b0;
                        state_next   = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            base_reg      <= BASE_RST;
            size_log2_reg <= SIZE_LOG2_RST;
            count_reg     <= COUNT_RST;
            vld_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            vld_reg      <= vld_next;
            chk_vld_reg  <= chk_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    CFG_BASE:      base_reg      <= cfg_wr_data[ADDR_W-1:0];
                    CFG_SIZE_LOG2: size_log2_reg <= cfg_wr_data[SIZE_LOG2_W-1:0];
                    CFG_COUNT:     count_reg     <= cfg_wr_data[COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        laddr_reg    <= laddr_next;
        baddr_reg    <= baddr_next;
        diff_reg     <= diff_next;
        status_reg   <= status_next;
        rd_idx_reg   <= rd_idx_next;
        chk_idx_reg  <= chk_idx_next;
        m_status_reg <= m_status_next;
        // valid bit travels with the memory read of the same entry
        rd_valid_reg <= vld_reg[ram_raddr] & (op_reg == OP_UNMAP);
    end

endmodule
